// ===== sv/vra_pkg.sv =====
package vra_pkg;

    localparam int VALUE_W = 32;
    localparam int RANK_W  = 7;

    // One input transaction
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last_in;
    } t_in;

    // One result transaction
    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic              last_out;
        logic              overflow;
    } t_out;

    // Probe travelling around the ring of cells
    typedef struct packed {
        logic                      valid;
        logic signed [VALUE_W-1:0] value;
    } t_probe;

    // Control broadcast from the sequencer to every cell
    typedef struct packed {
        logic init;   // load own value as probe, clear count
        logic step;   // compare probe, pass probe to next cell
        logic shift;  // move counts one cell toward the output
    } t_cell_ctrl;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_RANK,
        ST_EMIT
    } t_state;

endpackage

// ===== sv/vra_cell.sv =====
module vra_cell
    import vra_pkg::*;
#(
    parameter int CNT_W = 7
) (
    input  logic                      i_clk,
    input  t_cell_ctrl                i_ctrl,
    input  logic                      i_wr_en,
    input  logic signed [VALUE_W-1:0] i_wr_value,
    input  logic                      i_probe_valid,
    input  t_probe                    i_probe,
    output t_probe                    o_probe,
    input  logic [CNT_W-1:0]          i_count,
    output logic [CNT_W-1:0]          o_count
);

    logic signed [VALUE_W-1:0] r_value;
    t_probe                    r_probe;
    logic [CNT_W-1:0]          r_cnt;
    logic [CNT_W-1:0]          n_cnt;
    logic                      hit;

    // Count a probe that is not greater than the own value
    assign hit = i_probe.valid && ($signed(i_probe.value) <= $signed(r_value));

    always_comb begin
        n_cnt = r_cnt;
        if (i_ctrl.init) begin
            n_cnt = '0;
        end else if (i_ctrl.step) begin
            if (hit) begin
                n_cnt = r_cnt + CNT_W'(1);
            end
        end else if (i_ctrl.shift) begin
            n_cnt = i_count;
        end
    end

    // Hold own value, rotate probe, update count
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_value <= i_wr_value;
        end
        if (i_ctrl.init) begin
            r_probe.valid <= i_probe_valid;
            r_probe.value <= r_value;
        end else if (i_ctrl.step) begin
            r_probe <= i_probe;
        end
        r_cnt <= n_cnt;
    end

    assign o_probe = r_probe;
    assign o_count = r_cnt;

endmodule

// ===== sv/value_rank_assign.sv =====
// value_rank_assign: rank transform of a list of signed 32-bit values.
//
// Input channel (i_valid, i_data, o_stall): one value per transaction, up to
// one per cycle while loading. i_data.last_in closes the list. Values past
// MAX_VALUES are dropped and every result of that list carries overflow.
// Output channel (o_valid, o_data, i_stall): one rank per stored value, in
// arrival order, one per cycle while i_stall is low; last_out marks the final
// rank of the list. A stalled result holds until taken.
// Ranking: after the last value, the cells first load their own values as
// probes, then the probes rotate once around the ring of cells, each cell
// counting probes not greater than its own value. The first rank is offered
// only after this full sweep of the probes around the ring.
// o_stall is high from the last value until the final rank is taken.
// Reset: synchronous, active low; clears the list and returns to loading.
module value_rank_assign
    import vra_pkg::*;
#(
    parameter int MAX_VALUES = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_in  i_data,
    output logic o_stall,
    output logic o_valid,
    output t_out o_data,
    input  logic i_stall
);

    localparam int CNT_W = $clog2(MAX_VALUES + 1);
    localparam int IDX_W = $clog2(MAX_VALUES);

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] r_emit;
    logic [CNT_W-1:0] n_emit;
    logic [CNT_W-1:0] r_step;
    logic [CNT_W-1:0] n_step;
    logic             r_overflow;
    logic             n_overflow;

    logic             in_acc;
    logic             out_acc;
    logic             room;
    logic             emit_last;
    logic             rank_done;
    t_cell_ctrl       ctrl;

    t_probe           probe [MAX_VALUES];
    logic [CNT_W-1:0] cnt   [MAX_VALUES];

    assign in_acc    = i_valid && !o_stall;
    assign out_acc   = o_valid && !i_stall;
    assign room      = r_count < CNT_W'(MAX_VALUES);
    assign emit_last = CNT_W'(r_emit + CNT_W'(1)) == r_count;
    assign rank_done = r_step == CNT_W'(MAX_VALUES);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (in_acc && i_data.last_in) begin
                    n_state = ST_RANK;
                end
            end
            ST_RANK: begin
                if (rank_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_acc && emit_last) begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // Outputs and cell control
    always_comb begin
        o_stall = 1'b1;
        o_valid = 1'b0;
        ctrl    = '0;
        case (r_state)
            ST_LOAD: begin
                o_stall = 1'b0;
            end
            ST_RANK: begin
                ctrl.init = r_step == '0;
                ctrl.step = r_step != '0;
            end
            ST_EMIT: begin
                o_valid    = 1'b1;
                ctrl.shift = out_acc;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    // Counters for fill, ranking sweep and emission
    always_comb begin
        n_count    = r_count;
        n_overflow = r_overflow;
        n_step     = r_step;
        n_emit     = r_emit;
        if (in_acc) begin
            if (room) begin
                n_count = r_count + CNT_W'(1);
            end else begin
                n_overflow = 1'b1;
            end
            n_step = '0;
        end
        if (r_state == ST_RANK) begin
            n_step = r_step + CNT_W'(1);
        end
        if (out_acc) begin
            n_emit = r_emit + CNT_W'(1);
            if (emit_last) begin
                n_emit     = '0;
                n_count    = '0;
                n_overflow = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_count    <= '0;
            r_overflow <= 1'b0;
            r_step     <= '0;
            r_emit     <= '0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_overflow <= n_overflow;
            r_step     <= n_step;
            r_emit     <= n_emit;
        end
    end

    // Ring of cells: probes move up, counts move down toward cell 0
    for (genvar gi = 0; gi < MAX_VALUES; gi++) begin : g_cell
        localparam int PREV = (gi == 0) ? MAX_VALUES - 1 : gi - 1;
        localparam int NEXT = (gi == MAX_VALUES - 1) ? gi : gi + 1;

        logic wr_en;
        logic pv_init;

        assign wr_en   = in_acc && room && (r_count[IDX_W-1:0] == IDX_W'(gi));
        assign pv_init = CNT_W'(gi) < r_count;

        vra_cell #(
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (ctrl),
            .i_wr_en       (wr_en),
            .i_wr_value    (i_data.value),
            .i_probe_valid (pv_init),
            .i_probe       (probe[PREV]),
            .o_probe       (probe[gi]),
            .i_count       (cnt[NEXT]),
            .o_count       (cnt[gi])
        );
    end

    // Drive result from the head cell
    assign o_data.rank     = RANK_W'(cnt[0]);
    assign o_data.last_out = emit_last;
    assign o_data.overflow = r_overflow;

    // A result only exists for a non-empty list
    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_count != '0 && r_emit < r_count))
        else $error("result offered with emission index outside the list");

    // Input and output sides never run at the same time
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken while results are pending");

    // Final result returns the block to loading with an empty list
    a_list_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_data.last_out) |=> (!o_valid && !o_stall && r_count == '0))
        else $error("list not cleared after final result");

    // Fill count never exceeds capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_VALUES))
        else $error("stored count beyond capacity");

    // Ranks start only after the full sweep of probes
    a_sweep_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(rank_done))
        else $error("results offered before ranking sweep finished");

endmodule
